// ===== src/bcc_pkg.sv =====
// Shared types, codes and field widths of the bipartite co-occurrence counter.
package bcc_pkg;

    // Field widths of the stream items and the register port
    localparam int MODE_W      = 2;
    localparam int INT_FIELD_W = 6;
    localparam int EXT_FIELD_W = 8;
    localparam int MULT_W      = 8;
    localparam int DEG_W       = 14;
    localparam int COUNT_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int THRESH_W    = 14;
    localparam int INT_USE_W   = 7;
    localparam int EXT_USE_W   = 9;

    // Operation codes carried in tuser
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEG_THRESHOLD   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERNAL_IN_USE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXTERNAL_IN_USE = 2'd2;

    // Register reset values
    localparam logic [THRESH_W-1:0]  THRESH_RST  = 14'd0;
    localparam logic [INT_USE_W-1:0] INT_USE_RST = 7'd64;
    localparam logic [EXT_USE_W-1:0] EXT_USE_RST = 9'd256;

    // Saturation limits
    localparam logic [MULT_W-1:0] MULT_MAX = 8'hFF;
    localparam logic [DEG_W-1:0]  DEG_MAX  = 14'h3FFF;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_Q_WALK,
        ST_Q_DRAIN,
        ST_DONE
    } t_state;

    // Write enables into the store
    typedef struct packed {
        logic mult_we;
        logic deg_we;
    } t_store_wr;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

// ===== src/bipartite_cooccurrence_counter.sv =====
// Top level: sequencer, registers and stream ports of the co-occurrence counter.
//
// Holds edge multiplicities between internal and external hosts and the
// degree of each external host in block memories. An insert reads, checks
// and writes back before its result is given; a refused insert goes straight
// to the result. A query walks the in-use external hosts (the effective
// external_in_use, capped at EXTERNAL_HOSTS) one per cycle, reading both
// multiplicities and the degree in the same cycle, through a two-stage
// multiply-accumulate. A refused query, or one with no external host in use,
// goes straight to the result. A clear, and the clearing pass after reset,
// sweep the multiplicity memory one entry per cycle over the full address
// space of 2**(ceil(log2(INTERNAL_HOSTS)) + ceil(log2(EXTERNAL_HOSTS)))
// entries (16384 at the defaults), during which no item is accepted. One item
// is worked on at a time; the next item may be accepted while a result still
// waits on the output register. Register writes are always accepted.
module bipartite_cooccurrence_counter #(
    parameter int INTERNAL_HOSTS = 64,
    parameter int EXTERNAL_HOSTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bcc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [5:0] edge_internal, [13:6] edge_external, [19:14] query_row,
    // [25:20] query_col, [31:26] zero
    input  logic [bcc_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] mode
    input  logic [bcc_pkg::MODE_W-1:0]        i_s_tuser,
    // result items
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [23:0] shared_count, [25:24] status, [31:26] zero
    output logic [bcc_pkg::M_TDATA_W-1:0]     o_m_tdata
);

    localparam int IW  = $clog2(INTERNAL_HOSTS);
    localparam int EW  = (EXTERNAL_HOSTS > 1) ? $clog2(EXTERNAL_HOSTS) : 1;
    localparam int AW  = IW + EW;
    localparam int IXW = (IW > bcc_pkg::INT_FIELD_W) ? IW : bcc_pkg::INT_FIELD_W;
    localparam int EXW = (EW > bcc_pkg::EXT_FIELD_W) ? EW : bcc_pkg::EXT_FIELD_W;
    localparam int ICW = (IW + 1 > bcc_pkg::INT_USE_W) ? IW + 1 : bcc_pkg::INT_USE_W;
    localparam int ECL = $clog2(EXTERNAL_HOSTS + 1);
    localparam int ECW = (ECL > bcc_pkg::EXT_USE_W) ? ECL : bcc_pkg::EXT_USE_W;

    // Registers
    logic [bcc_pkg::THRESH_W-1:0]   r_thresh;
    logic [bcc_pkg::INT_USE_W-1:0]  r_int_use;
    logic [bcc_pkg::EXT_USE_W-1:0]  r_ext_use;

    bcc_pkg::t_state                r_state, n_state;
    logic [AW-1:0]                  r_sweep, n_sweep;
    logic                           r_sweep_item, n_sweep_item;
    logic [ECW-1:0]                 r_walk, n_walk;
    logic                           r_drain, n_drain;
    logic                           r_rd_vld;
    logic [IW-1:0]                  r_row, n_row;
    logic [IW-1:0]                  r_col, n_col;
    logic [EW-1:0]                  r_ext, n_ext;
    logic [bcc_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                           r_use_sum, n_use_sum;
    logic                           r_out_valid, n_out_valid;
    logic [bcc_pkg::COUNT_W-1:0]    r_out_count, n_out_count;
    logic [bcc_pkg::STATUS_W-1:0]   r_out_status, n_out_status;

    // Input fields
    logic [bcc_pkg::MODE_W-1:0]       w_mode;
    logic [bcc_pkg::INT_FIELD_W-1:0]  w_edge_int;
    logic [bcc_pkg::EXT_FIELD_W-1:0]  w_edge_ext;
    logic [bcc_pkg::INT_FIELD_W-1:0]  w_q_row;
    logic [bcc_pkg::INT_FIELD_W-1:0]  w_q_col;
    logic [IXW-1:0]                   w_edge_int_x, w_q_row_x, w_q_col_x;
    logic [EXW-1:0]                   w_edge_ext_x;

    logic [ICW-1:0]                 w_int_lim;
    logic [ECW-1:0]                 w_ext_lim;
    logic                           w_accept;
    logic                           w_ins_ok;
    logic                           w_q_ok;
    logic                           w_walk_last;
    logic                           w_sat;
    logic [EW-1:0]                  w_e_addr;

    // Store and accumulator connections
    bcc_pkg::t_store_wr             w_wr;
    bcc_pkg::t_mac_ctl              w_mac;
    logic [AW-1:0]                  w_mult_waddr;
    logic [bcc_pkg::MULT_W-1:0]     w_mult_wdata;
    logic [EW-1:0]                  w_deg_waddr;
    logic [bcc_pkg::DEG_W-1:0]      w_deg_wdata;
    logic [bcc_pkg::MULT_W-1:0]     w_mult_a, w_mult_b;
    logic [bcc_pkg::DEG_W-1:0]      w_deg;
    logic [bcc_pkg::COUNT_W-1:0]    w_sum;

    // Unpack the input item
    assign w_mode     = i_s_tuser;
    assign w_edge_int = i_s_tdata[5:0];
    assign w_edge_ext = i_s_tdata[13:6];
    assign w_q_row    = i_s_tdata[19:14];
    assign w_q_col    = i_s_tdata[25:20];

    assign w_edge_int_x = IXW'(w_edge_int);
    assign w_q_row_x    = IXW'(w_q_row);
    assign w_q_col_x    = IXW'(w_q_col);
    assign w_edge_ext_x = EXW'(w_edge_ext);

    // Cap the in-use counts at the store size
    assign w_int_lim = (ICW'(r_int_use) > ICW'(INTERNAL_HOSTS)) ?
                       ICW'(INTERNAL_HOSTS) : ICW'(r_int_use);
    assign w_ext_lim = (ECW'(r_ext_use) > ECW'(EXTERNAL_HOSTS)) ?
                       ECW'(EXTERNAL_HOSTS) : ECW'(r_ext_use);

    assign w_ins_ok = (ICW'(w_edge_int) < w_int_lim) && (ECW'(w_edge_ext) < w_ext_lim);
    assign w_q_ok   = (ICW'(w_q_row) < w_int_lim) && (ICW'(w_q_col) < w_int_lim);

    assign o_s_tready  = (r_state == bcc_pkg::ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_walk_last = (r_walk == w_ext_lim - ECW'(1));
    assign w_sat       = (w_mult_a == bcc_pkg::MULT_MAX) || (w_deg == bcc_pkg::DEG_MAX);
    assign w_e_addr    = (r_state == bcc_pkg::ST_Q_WALK) ? r_walk[EW-1:0] : r_ext;

    // Register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= bcc_pkg::THRESH_RST;
            r_int_use <= bcc_pkg::INT_USE_RST;
            r_ext_use <= bcc_pkg::EXT_USE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                bcc_pkg::CFG_DEG_THRESHOLD:
                    r_thresh <= i_cfg_data[bcc_pkg::THRESH_W-1:0];
                bcc_pkg::CFG_INTERNAL_IN_USE:
                    r_int_use <= i_cfg_data[bcc_pkg::INT_USE_W-1:0];
                bcc_pkg::CFG_EXTERNAL_IN_USE:
                    r_ext_use <= i_cfg_data[bcc_pkg::EXT_USE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Store write port: sweep zeros, or write back an insert
    always_comb begin
        if (r_state == bcc_pkg::ST_SWEEP) begin
            w_mult_waddr = r_sweep;
            w_mult_wdata = '0;
            w_deg_waddr  = r_sweep[EW-1:0];
            w_deg_wdata  = '0;
        end else begin
            w_mult_waddr = {r_row, r_ext};
            w_mult_wdata = w_mult_a + bcc_pkg::MULT_W'(1);
            w_deg_waddr  = r_ext;
            w_deg_wdata  = w_deg + bcc_pkg::DEG_W'(1);
        end
    end

    // Sequencer: next state and per-item bookkeeping
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_sweep_item = r_sweep_item;
        n_walk       = r_walk;
        n_drain      = r_drain;
        n_row        = r_row;
        n_col        = r_col;
        n_ext        = r_ext;
        n_status     = r_status;
        n_use_sum    = r_use_sum;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        w_wr         = '0;
        w_mac        = '0;

        unique case (r_state)
            bcc_pkg::ST_SWEEP: begin
                w_wr.mult_we = 1'b1;
                w_wr.deg_we  = 1'b1;
                n_sweep      = r_sweep + AW'(1);
                if (r_sweep == '1) begin
                    n_state = r_sweep_item ? bcc_pkg::ST_DONE : bcc_pkg::ST_IDLE;
                end
            end
            bcc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_status  = bcc_pkg::STATUS_OK;
                    n_use_sum = 1'b0;
                    n_state   = bcc_pkg::ST_DONE;
                    unique case (w_mode)
                        bcc_pkg::MODE_INSERT: begin
                            n_row = w_edge_int_x[IW-1:0];
                            n_ext = w_edge_ext_x[EW-1:0];
                            if (w_ins_ok) begin
                                n_state = bcc_pkg::ST_INS_RD;
                            end else begin
                                n_status = bcc_pkg::STATUS_RANGE;
                            end
                        end
                        bcc_pkg::MODE_QUERY: begin
                            n_row = w_q_row_x[IW-1:0];
                            n_col = w_q_col_x[IW-1:0];
                            w_mac.clear = 1'b1;
                            n_walk  = '0;
                            n_drain = 1'b0;
                            if (!w_q_ok) begin
                                n_status = bcc_pkg::STATUS_RANGE;
                            end else if (w_ext_lim != '0) begin
                                n_use_sum = 1'b1;
                                n_state   = bcc_pkg::ST_Q_WALK;
                            end
                        end
                        bcc_pkg::MODE_CLEAR: begin
                            n_sweep      = '0;
                            n_sweep_item = 1'b1;
                            n_state      = bcc_pkg::ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bcc_pkg::ST_INS_RD: begin
                n_state = bcc_pkg::ST_INS_WR;
            end
            bcc_pkg::ST_INS_WR: begin
                if (w_sat) begin
                    n_status = bcc_pkg::STATUS_SAT;
                end else begin
                    w_wr.mult_we = 1'b1;
                    w_wr.deg_we  = 1'b1;
                end
                n_state = bcc_pkg::ST_DONE;
            end
            bcc_pkg::ST_Q_WALK: begin
                n_walk = r_walk + ECW'(1);
                if (w_walk_last) begin
                    n_state = bcc_pkg::ST_Q_DRAIN;
                end
            end
            bcc_pkg::ST_Q_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = bcc_pkg::ST_DONE;
                end
            end
            bcc_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = r_use_sum ? w_sum : '0;
                    n_out_status = r_status;
                    n_state      = bcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bcc_pkg::ST_IDLE;
            end
        endcase

        w_mac.valid = r_rd_vld;
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bcc_pkg::ST_SWEEP;
            r_sweep      <= '0;
            r_sweep_item <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_sweep_item <= (n_state == bcc_pkg::ST_IDLE) ? 1'b0 : n_sweep_item;
            r_rd_vld     <= (r_state == bcc_pkg::ST_Q_WALK);
            r_out_valid  <= n_out_valid;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        r_walk       <= n_walk;
        r_drain      <= n_drain;
        r_row        <= n_row;
        r_col        <= n_col;
        r_ext        <= n_ext;
        r_status     <= n_status;
        r_use_sum    <= n_use_sum;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    bcc_store #(
        .INTERNAL_HOSTS (INTERNAL_HOSTS),
        .EXTERNAL_HOSTS (EXTERNAL_HOSTS)
    ) u_store (
        .i_clk          (i_clk),
        .i_wr           (w_wr),
        .i_mult_waddr   (w_mult_waddr),
        .i_mult_wdata   (w_mult_wdata),
        .i_deg_waddr    (w_deg_waddr),
        .i_deg_wdata    (w_deg_wdata),
        .i_mult_raddr_a ({r_row, w_e_addr}),
        .i_mult_raddr_b ({r_col, w_e_addr}),
        .i_deg_raddr    (w_e_addr),
        .o_mult_a       (w_mult_a),
        .o_mult_b       (w_mult_b),
        .o_deg          (w_deg)
    );

    bcc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mac),
        .i_mult_a    (w_mult_a),
        .i_mult_b    (w_mult_b),
        .i_degree    (w_deg),
        .i_threshold (r_thresh),
        .o_sum       (w_sum)
    );

    // Pack the result item
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(bcc_pkg::M_TDATA_W - bcc_pkg::COUNT_W - bcc_pkg::STATUS_W)'(0),
                         r_out_status, r_out_count};

endmodule

// ===== src/bcc_store.sv =====
// Edge multiplicity memory (two read ports) and external degree memory.
module bcc_store #(
    parameter int INTERNAL_HOSTS = 64,
    parameter int EXTERNAL_HOSTS = 256,
    localparam int IW = $clog2(INTERNAL_HOSTS),
    localparam int EW = (EXTERNAL_HOSTS > 1) ? $clog2(EXTERNAL_HOSTS) : 1,
    localparam int AW = IW + EW
) (
    input  logic                        i_clk,
    input  bcc_pkg::t_store_wr          i_wr,
    input  logic [AW-1:0]               i_mult_waddr,
    input  logic [bcc_pkg::MULT_W-1:0]  i_mult_wdata,
    input  logic [EW-1:0]               i_deg_waddr,
    input  logic [bcc_pkg::DEG_W-1:0]   i_deg_wdata,
    input  logic [AW-1:0]               i_mult_raddr_a,
    input  logic [AW-1:0]               i_mult_raddr_b,
    input  logic [EW-1:0]               i_deg_raddr,
    output logic [bcc_pkg::MULT_W-1:0]  o_mult_a,
    output logic [bcc_pkg::MULT_W-1:0]  o_mult_b,
    output logic [bcc_pkg::DEG_W-1:0]   o_deg
);

    localparam int MDEPTH = INTERNAL_HOSTS << EW;
    localparam int DDEPTH = 1 << EW;

    logic [bcc_pkg::MULT_W-1:0] r_mult_mem [MDEPTH];
    logic [bcc_pkg::DEG_W-1:0]  r_deg_mem  [DDEPTH];

    // Write one multiplicity per cycle, read two with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr.mult_we) begin
            r_mult_mem[i_mult_waddr] <= i_mult_wdata;
        end
        o_mult_a <= r_mult_mem[i_mult_raddr_a];
        o_mult_b <= r_mult_mem[i_mult_raddr_b];
    end

    // Write and read one degree per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.deg_we) begin
            r_deg_mem[i_deg_waddr] <= i_deg_wdata;
        end
        o_deg <= r_deg_mem[i_deg_raddr];
    end

endmodule

// ===== src/bcc_mac.sv =====
// Degree-filtered multiply-accumulate with a saturating 24-bit sum.
module bcc_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcc_pkg::t_mac_ctl             i_ctl,
    input  logic [bcc_pkg::MULT_W-1:0]    i_mult_a,
    input  logic [bcc_pkg::MULT_W-1:0]    i_mult_b,
    input  logic [bcc_pkg::DEG_W-1:0]     i_degree,
    input  logic [bcc_pkg::THRESH_W-1:0]  i_threshold,
    output logic [bcc_pkg::COUNT_W-1:0]   o_sum
);

    localparam int PW = 2 * bcc_pkg::MULT_W;

    logic [PW-1:0]                 r_prod;
    logic                          r_prod_vld;
    logic [bcc_pkg::COUNT_W-1:0]   r_sum;
    logic [bcc_pkg::COUNT_W-1:0]   n_sum;
    logic [bcc_pkg::COUNT_W:0]     w_add;
    logic                          w_keep;

    // Skip external hosts whose degree is above the threshold
    assign w_keep = (i_degree <= i_threshold);

    // Saturate the running sum
    always_comb begin
        w_add = {1'b0, r_sum} + (bcc_pkg::COUNT_W + 1)'(r_prod);
        n_sum = w_add[bcc_pkg::COUNT_W] ? '1 : w_add[bcc_pkg::COUNT_W-1:0];
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.valid && w_keep;
        end
        r_prod <= i_mult_a * i_mult_b;
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (r_prod_vld) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== src/bcc_checker.sv =====
// Port-level checks of the co-occurrence counter, bound to the top level.
module bcc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [bcc_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted while the previous one is in work");

    // Status is never the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[25:24] != bcc_pkg::STATUS_BAD))
        else $error("result carries an unused status code");

    // A refused or saturated item reports a zero count
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[25:24] != bcc_pkg::STATUS_OK))
        |-> (o_m_tdata[23:0] == '0))
        else $error("nonzero count with a non-ok status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind bipartite_cooccurrence_counter bcc_checker u_bcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/tb_bipartite_cooccurrence_counter.sv =====
// Self-checking testbench for the co-occurrence counter: directed table, then random phases.
module tb_bipartite_cooccurrence_counter;

    localparam int INTERNAL_HOSTS = 64;
    localparam int EXTERNAL_HOSTS = 256;

    // Bit positions of the request fields inside s_tdata
    localparam int EI_LSB = 0;
    localparam int EE_LSB = EI_LSB + bcc_pkg::INT_FIELD_W;
    localparam int QR_LSB = EE_LSB + bcc_pkg::EXT_FIELD_W;
    localparam int QC_LSB = QR_LSB + bcc_pkg::INT_FIELD_W;

    // Unused operation code: the block must answer it and change nothing
    localparam logic [bcc_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_PHASES      = 8;
    localparam int GAP_PCT         = 54;
    localparam int BOTH_GAP_PCT    = 28;

    typedef struct packed {
        logic [bcc_pkg::COUNT_W-1:0]  shared_count;
        logic [bcc_pkg::STATUS_W-1:0] status;
    } t_result;

    typedef enum {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        t_row_kind                    kind;
        logic [1:0]                   code;
        int                           a;
        int                           b;
        bit                           known;
        int                           cnt;
        logic [bcc_pkg::STATUS_W-1:0] st;
    } t_dir_row;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [bcc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr  = '0;
    logic [bcc_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [bcc_pkg::S_TDATA_W-1:0]    i_s_tdata   = '0;
    logic [bcc_pkg::MODE_W-1:0]       i_s_tuser   = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [bcc_pkg::M_TDATA_W-1:0]    o_m_tdata;

    // Shadow copy of the store and registers
    logic [bcc_pkg::MULT_W-1:0]    mult_store [INTERNAL_HOSTS][EXTERNAL_HOSTS];
    logic [bcc_pkg::DEG_W-1:0]     deg_store  [EXTERNAL_HOSTS];
    logic [bcc_pkg::THRESH_W-1:0]  thr_reg;
    logic [bcc_pkg::INT_USE_W-1:0] int_use_reg;
    logic [bcc_pkg::EXT_USE_W-1:0] ext_use_reg;

    t_result  pending_results [$];
    t_dir_row dir_rows [$];
    t_idle    idle_mode = IDLE_NONE;

    int n_items, n_insert, n_sat, n_query, n_hit, n_clear, n_nop, n_range;
    int n_checked, n_mismatch;

    bipartite_cooccurrence_counter #(
        .INTERNAL_HOSTS (INTERNAL_HOSTS),
        .EXTERNAL_HOSTS (EXTERNAL_HOSTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Idle percentage of the current phase
    function automatic int gap_pct();
        return (idle_mode == IDLE_BOTH) ? BOTH_GAP_PCT : GAP_PCT;
    endfunction

    // Effective in-use counts, capped at the store size
    function automatic int used_internal();
        return (int_use_reg > INTERNAL_HOSTS) ? INTERNAL_HOSTS : int'(int_use_reg);
    endfunction

    function automatic int used_external();
        return (ext_use_reg > EXTERNAL_HOSTS) ? EXTERNAL_HOSTS : int'(ext_use_reg);
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < INTERNAL_HOSTS; i++) begin
            for (int e = 0; e < EXTERNAL_HOSTS; e++) begin
                mult_store[i][e] = '0;
            end
        end
        for (int e = 0; e < EXTERNAL_HOSTS; e++) begin
            deg_store[e] = '0;
        end
    endfunction

    function automatic logic [bcc_pkg::S_TDATA_W-1:0] pack_fields(input int ei, input int ee,
                                                                  input int qr, input int qc);
        logic [bcc_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[EI_LSB +: bcc_pkg::INT_FIELD_W] = ei[bcc_pkg::INT_FIELD_W-1:0];
        d[EE_LSB +: bcc_pkg::EXT_FIELD_W] = ee[bcc_pkg::EXT_FIELD_W-1:0];
        d[QR_LSB +: bcc_pkg::INT_FIELD_W] = qr[bcc_pkg::INT_FIELD_W-1:0];
        d[QC_LSB +: bcc_pkg::INT_FIELD_W] = qc[bcc_pkg::INT_FIELD_W-1:0];
        return d;
    endfunction

    // Apply one request to the shadow store and return the result it yields
    function automatic t_result apply_request(input logic [bcc_pkg::MODE_W-1:0] mode,
                                              input logic [bcc_pkg::S_TDATA_W-1:0] data);
        t_result r;
        int      ni;
        int      ne;
        int      i;
        int      e;
        int      rr;
        int      cc;
        longint  sum;
        r.shared_count = '0;
        r.status       = bcc_pkg::STATUS_OK;
        ni  = used_internal();
        ne  = used_external();
        sum = 0;
        n_items++;
        case (mode)
            bcc_pkg::MODE_INSERT: begin
                n_insert++;
                i = data[EI_LSB +: bcc_pkg::INT_FIELD_W];
                e = data[EE_LSB +: bcc_pkg::EXT_FIELD_W];
                if (i >= ni || e >= ne) begin
                    r.status = bcc_pkg::STATUS_RANGE;
                end else if (mult_store[i][e] == bcc_pkg::MULT_MAX ||
                             deg_store[e] == bcc_pkg::DEG_MAX) begin
                    r.status = bcc_pkg::STATUS_SAT;
                    n_sat++;
                end else begin
                    mult_store[i][e] = mult_store[i][e] + 1'b1;
                    deg_store[e]     = deg_store[e] + 1'b1;
                end
            end
            bcc_pkg::MODE_QUERY: begin
                n_query++;
                rr = data[QR_LSB +: bcc_pkg::INT_FIELD_W];
                cc = data[QC_LSB +: bcc_pkg::INT_FIELD_W];
                if (rr >= ni || cc >= ni) begin
                    r.status = bcc_pkg::STATUS_RANGE;
                end else begin
                    // skip external hosts whose degree is above the threshold
                    for (e = 0; e < ne; e++) begin
                        if (deg_store[e] <= thr_reg) begin
                            sum = sum + longint'(mult_store[rr][e]) *
                                        longint'(mult_store[cc][e]);
                            if (sum > 64'hFF_FFFF) sum = 64'hFF_FFFF;
                        end
                    end
                    r.shared_count = sum[bcc_pkg::COUNT_W-1:0];
                    if (sum != 0) n_hit++;
                end
            end
            bcc_pkg::MODE_CLEAR: begin
                n_clear++;
                wipe_store();
            end
            default: begin
                n_nop++;
            end
        endcase
        if (r.status == bcc_pkg::STATUS_RANGE) n_range++;
        return r;
    endfunction

    // Compare each accepted result with the oldest expectation; drive tready
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (o_m_tvalid && i_m_tready) begin
            got.shared_count = o_m_tdata[bcc_pkg::COUNT_W-1:0];
            got.status       = o_m_tdata[bcc_pkg::COUNT_W +: bcc_pkg::STATUS_W];
            n_checked++;
            if (pending_results.size() == 0) begin
                if (n_mismatch < 10)
                    $display("unexpected result: count=%0d status=%0d",
                             got.shared_count, got.status);
                n_mismatch++;
            end else begin
                want = pending_results.pop_front();
                if (got.shared_count !== want.shared_count || got.status !== want.status) begin
                    if (n_mismatch < 10)
                        $display("result %0d: expected count=%0d status=%0d, %s",
                                 n_checked, want.shared_count, want.status,
                                 $sformatf("got count=%0d status=%0d",
                                           got.shared_count, got.status));
                    n_mismatch++;
                end
            end
        end
        if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            i_m_tready <= ($urandom_range(0, 99) >= gap_pct());
        else
            i_m_tready <= 1'b1;
    end

    task automatic send_request(input logic [bcc_pkg::MODE_W-1:0] mode,
                                input logic [bcc_pkg::S_TDATA_W-1:0] data,
                                input bit known, input t_result typed);
        t_result pred;
        // hold the item back for a random number of cycles
        while ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
               $urandom_range(0, 99) < gap_pct()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        pred = apply_request(mode, data);
        pending_results.insert(pending_results.size(), known ? typed : pred);
    endtask

    task automatic write_reg(input logic [bcc_pkg::CFG_ADDR_W-1:0] addr, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value[bcc_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (addr)
            bcc_pkg::CFG_DEG_THRESHOLD:   thr_reg     = value[bcc_pkg::THRESH_W-1:0];
            bcc_pkg::CFG_INTERNAL_IN_USE: int_use_reg = value[bcc_pkg::INT_USE_W-1:0];
            bcc_pkg::CFG_EXTERNAL_IN_USE: ext_use_reg = value[bcc_pkg::EXT_USE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic settle_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on a small set of hosts so multiplicities build up
    task automatic random_request();
        int                         pick;
        int                         ni;
        int                         ne;
        int                         hot_i;
        int                         hot_e;
        int                         ei;
        int                         ee;
        int                         qr;
        int                         qc;
        bit                         well;
        logic [bcc_pkg::MODE_W-1:0] mode;
        t_result                    none;
        none  = '0;
        ni    = used_internal();
        ne    = used_external();
        hot_i = (ni < 6) ? ni : 6;
        hot_e = (ne < 12) ? ne : 12;
        ei    = $urandom_range(0, 63);
        ee    = $urandom_range(0, 255);
        qr    = $urandom_range(0, 63);
        qc    = $urandom_range(0, 63);
        well  = ($urandom_range(0, 99) < 85) && ni > 0 && ne > 0;
        pick  = $urandom_range(0, 99);
        if (pick == 0) begin
            mode = bcc_pkg::MODE_CLEAR;
        end else if (pick < 4) begin
            mode = MODE_NOP;
        end else if (pick < 56) begin
            mode = bcc_pkg::MODE_INSERT;
            if (well) begin
                if ($urandom_range(0, 3) != 0) begin
                    ei = $urandom_range(0, hot_i - 1);
                    ee = $urandom_range(0, hot_e - 1);
                end else begin
                    ei = $urandom_range(0, ni - 1);
                    ee = $urandom_range(0, ne - 1);
                end
            end
        end else begin
            mode = bcc_pkg::MODE_QUERY;
            if (well) begin
                qr = $urandom_range(0, hot_i - 1);
                qc = $urandom_range(0, hot_i - 1);
            end
        end
        send_request(mode, pack_fields(ei, ee, qr, qc), 1'b0, none);
    endtask

    function automatic void add_item(input logic [bcc_pkg::MODE_W-1:0] mode,
                                     input int a, input int b,
                                     input bit known, input int cnt,
                                     input logic [bcc_pkg::STATUS_W-1:0] st);
        t_dir_row row;
        row = '{ROW_ITEM, mode, a, b, known, cnt, st};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_cfg(input logic [bcc_pkg::CFG_ADDR_W-1:0] addr,
                                    input int value);
        t_dir_row row;
        row = '{ROW_CFG, addr, value, 0, 1'b0, 0, bcc_pkg::STATUS_OK};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Ends a hung run
    initial begin
        #160_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [bcc_pkg::S_TDATA_W-1:0] data;
        t_result                       typed;
        int                            thr;
        int                            iu;
        int                            eu;

        wipe_store();
        thr_reg     = bcc_pkg::THRESH_RST;
        int_use_reg = bcc_pkg::INT_USE_RST;
        ext_use_reg = bcc_pkg::EXT_USE_RST;

        // Directed table: empty store, extremes, range refusals, unused code, clear
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  63,  63,  1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_INSERT, 0,   0,   1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_INSERT, 63,  255, 1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_INSERT, 0,   0,   1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   0, 0, bcc_pkg::STATUS_OK);
        add_cfg(bcc_pkg::CFG_DEG_THRESHOLD, 16383);
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   0, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  63,  63,  0, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  0,   63,  0, 0, bcc_pkg::STATUS_OK);
        add_item(MODE_NOP,             63,  63,  1, 0, bcc_pkg::STATUS_OK);
        add_cfg(bcc_pkg::CFG_INTERNAL_IN_USE, 0);
        add_item(bcc_pkg::MODE_INSERT, 0,   0,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   1, 0, bcc_pkg::STATUS_RANGE);
        add_cfg(bcc_pkg::CFG_INTERNAL_IN_USE, 127);
        add_cfg(bcc_pkg::CFG_EXTERNAL_IN_USE, 511);
        add_item(bcc_pkg::MODE_INSERT, 63,  255, 0, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  63,  63,  0, 0, bcc_pkg::STATUS_OK);
        add_cfg(bcc_pkg::CFG_INTERNAL_IN_USE, 1);
        add_cfg(bcc_pkg::CFG_EXTERNAL_IN_USE, 1);
        add_item(bcc_pkg::MODE_INSERT, 1,   0,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_INSERT, 0,   1,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_QUERY,  0,   1,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_QUERY,  1,   0,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_INSERT, 0,   0,   0, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   0, 0, bcc_pkg::STATUS_OK);
        add_cfg(bcc_pkg::CFG_EXTERNAL_IN_USE, 0);
        add_item(bcc_pkg::MODE_INSERT, 0,   0,   1, 0, bcc_pkg::STATUS_RANGE);
        add_item(bcc_pkg::MODE_CLEAR,  0,   0,   1, 0, bcc_pkg::STATUS_OK);
        add_item(bcc_pkg::MODE_QUERY,  0,   0,   1, 0, bcc_pkg::STATUS_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_rows[k].code, dir_rows[k].a);
            end else begin
                case (dir_rows[k].code)
                    bcc_pkg::MODE_INSERT:
                        data = pack_fields(dir_rows[k].a, dir_rows[k].b, 0, 0);
                    bcc_pkg::MODE_QUERY:
                        data = pack_fields(0, 0, dir_rows[k].a, dir_rows[k].b);
                    default:
                        data = pack_fields(63, 255, 63, 63);
                endcase
                typed.shared_count = dir_rows[k].cnt[bcc_pkg::COUNT_W-1:0];
                typed.status       = dir_rows[k].st;
                send_request(dir_rows[k].code, data, dir_rows[k].known, typed);
            end
        end

        // Random phases, each with its own register setting and idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            case (ph)
                0:       begin thr = 16383; iu = 64;  eu = 256; end
                1:       begin thr = 8;     iu = 64;  eu = 256; end
                2:       begin thr = 3;     iu = 16;  eu = 32;  end
                3:       begin thr = 16320; iu = 127; eu = 511; end
                4:       begin thr = 0;     iu = 1;   eu = 1;   end
                5:       begin thr = 20;    iu = 40;  eu = 100; end
                6: begin
                    thr = $urandom_range(0, 40);
                    iu  = $urandom_range(1, 64);
                    eu  = $urandom_range(1, 256);
                end
                default: begin
                    thr = $urandom_range(0, 16383);
                    iu  = $urandom_range(0, 127);
                    eu  = $urandom_range(0, 511);
                end
            endcase
            idle_mode = t_idle'(ph % 4);
            write_reg(bcc_pkg::CFG_DEG_THRESHOLD, thr);
            write_reg(bcc_pkg::CFG_INTERNAL_IN_USE, iu);
            write_reg(bcc_pkg::CFG_EXTERNAL_IN_USE, eu);

            // Drive one edge to full multiplicity and past it
            if (ph == 0) begin
                typed = '0;
                repeat (int'(bcc_pkg::MULT_MAX) + 2)
                    send_request(bcc_pkg::MODE_INSERT, pack_fields(5, 7, 0, 0), 1'b0, typed);
                send_request(bcc_pkg::MODE_QUERY, pack_fields(0, 0, 5, 5), 1'b0, typed);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // hold the sender until the block has drained
                if (n == ITEMS_PER_PHASE / 2) settle_idle();
                random_request();
            end
        end

        settle_idle();
        repeat (EXTERNAL_HOSTS) @(posedge i_clk);

        $display("Checked %0d results over %0d items: %0d inserts (%0d saturated), %0d queries",
                 n_checked, n_items, n_insert, n_sat, n_query);
        $display("  (%0d nonzero), %0d clears, %0d unused codes, %0d refused for range",
                 n_hit, n_clear, n_nop, n_range);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
